FILE: rtl/core/irt_pkg.sv
// Shared types for the interval reservation table.
package irt_pkg;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_e;

  // control part of the request token walking down the cell chain
  typedef struct packed {
    logic vld;
    logic clash;
  } tok_ctl_t;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned UsedWidth  = 7;

endpackage

FILE: rtl/core/interval_reservation_table.sv
// Interval reservation table: books requests unless invalid, overlapping or table full.
// A request [range_start_i, range_end_i) is taken when start_i is high and busy_o is low.
// An empty or reversed interval answers with status 3 on the next cycle and the block is free
// again at once. Any other request walks down a chain of ENTRIES cells, one cell per cycle,
// each comparing it against the interval it holds; it passes the injection register and every
// cell register, then valid_o rises; a new request can be taken in that same cycle, so
// the block takes no new valid request while one is in the chain. Intervals are never removed,
// so bookings fill the cells in order. Each result is shown for one cycle with valid_o high and
// must be taken then: the block does not wait for the receiver.
module interval_reservation_table #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] range_start_i,
  input  logic [31:0] range_end_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [6:0]  entries_used_o
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  irt_pkg::fsm_e     state_d, state_q;
  irt_pkg::status_e  status_d, status_q;
  irt_pkg::tok_ctl_t inj_ctl_d, inj_ctl_q;
  logic [TW-1:0]     inj_start_q, inj_end_q;
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic              valid_d, valid_q;
  logic [6:0]        used_d, used_q;
  logic              launch, wr_en;
  logic [TW-1:0]     req_start, req_end;

  irt_pkg::tok_ctl_t ctl_c   [ENTRIES+1];
  logic [TW-1:0]     start_c [ENTRIES+1];
  logic [TW-1:0]     end_c   [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vld;

  assign req_start = TW'(range_start_i);
  assign req_end   = TW'(range_end_i);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    launch   = 1'b0;
    wr_en    = 1'b0;
    unique case (state_q)
      irt_pkg::FSM_IDLE: begin
        if (start_i) begin
          if (req_start >= req_end) begin
            valid_d  = 1'b1;
            status_d = irt_pkg::ST_INVALID;
          end else begin
            launch  = 1'b1;
            state_d = irt_pkg::FSM_SCAN;
          end
        end
      end
      irt_pkg::FSM_SCAN: begin
        if (ctl_c[ENTRIES].vld) begin
          state_d = irt_pkg::FSM_IDLE;
          valid_d = 1'b1;
          if (ctl_c[ENTRIES].clash) begin
            status_d = irt_pkg::ST_OVERLAP;
          end else if (cnt_q == CNT_W'(ENTRIES)) begin
            status_d = irt_pkg::ST_FULL;
          end else begin
            status_d = irt_pkg::ST_BOOKED;
            wr_en    = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = irt_pkg::FSM_IDLE;
    endcase
    inj_ctl_d.vld   = launch;
    inj_ctl_d.clash = 1'b0;
    used_d          = 7'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= irt_pkg::FSM_IDLE;
      cnt_q     <= '0;
      valid_q   <= 1'b0;
      inj_ctl_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      inj_ctl_q <= inj_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      inj_start_q <= req_start;
      inj_end_q   <= req_end;
    end
    if (valid_d) begin
      status_q <= status_d;
      used_q   <= used_d;
    end
  end

  assign ctl_c[0]   = inj_ctl_q;
  assign start_c[0] = inj_start_q;
  assign end_c[0]   = inj_end_q;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    irt_cell #(
      .TW(TW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .slot_valid_i(cnt_q > CNT_W'(i)),
      .wr_en_i     (wr_en && (cnt_q == CNT_W'(i))),
      .wr_start_i  (start_c[ENTRIES]),
      .wr_end_i    (end_c[ENTRIES]),
      .ctl_i       (ctl_c[i]),
      .tok_start_i (start_c[i]),
      .tok_end_i   (end_c[i]),
      .ctl_o       (ctl_c[i+1]),
      .tok_start_o (start_c[i+1]),
      .tok_end_o   (end_c[i+1])
    );
    assign tok_vld[i] = ctl_c[i+1].vld;
  end

  assign busy_o         = (state_q != irt_pkg::FSM_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign entries_used_o = used_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one request token in the cell chain");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_c[ENTRIES].vld |-> state_q == irt_pkg::FSM_SCAN)
    else $error("request token leaves the chain outside a scan");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  a_booked_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == irt_pkg::ST_BOOKED) |-> cnt_q == $past(cnt_q) + 1'b1)
    else $error("booking without count increment");

  a_valid_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_start < req_end) |=> busy_o)
    else $error("valid request did not start a scan");

endmodule

FILE: rtl/core/irt_cell.sv
// One table cell: holds one interval, checks the passing request token.
module irt_cell #(
  parameter int unsigned TW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              slot_valid_i,
  input  logic              wr_en_i,
  input  logic [TW-1:0]     wr_start_i,
  input  logic [TW-1:0]     wr_end_i,
  input  irt_pkg::tok_ctl_t ctl_i,
  input  logic [TW-1:0]     tok_start_i,
  input  logic [TW-1:0]     tok_end_i,
  output irt_pkg::tok_ctl_t ctl_o,
  output logic [TW-1:0]     tok_start_o,
  output logic [TW-1:0]     tok_end_o
);

  logic [TW-1:0]     slot_start_q;
  logic [TW-1:0]     slot_end_q;
  irt_pkg::tok_ctl_t ctl_d, ctl_q;
  logic [TW-1:0]     tok_start_q;
  logic [TW-1:0]     tok_end_q;
  logic              hit;

  assign hit = slot_valid_i && (slot_start_q < tok_end_i) && (tok_start_i < slot_end_q);

  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.clash = ctl_i.clash | (ctl_i.vld & hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_start_q <= tok_start_i;
    tok_end_q   <= tok_end_i;
    if (wr_en_i) begin
      slot_start_q <= wr_start_i;
      slot_end_q   <= wr_end_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign tok_start_o = tok_start_q;
  assign tok_end_o   = tok_end_q;

endmodule
